// ===== sv/ncw_pkg.sv =====
// ncw_pkg: shared types, codes and helpers for the NewReno congestion window block.
// No dependencies; used by every module under sv/.

package ncw_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_IDX_INIT_WINDOW = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IDX_MIN_WINDOW = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_IDX_MAX_DGRAM = 2'd2;

  localparam logic [31:0] INIT_WINDOW_RST = 32'd12000;
  localparam logic [31:0] MIN_WINDOW_RST = 32'd2400;
  localparam logic [15:0] MAX_DGRAM_RST = 16'd1200;

  localparam logic [63:0] ALL_ONES = {64{1'b1}};

  // packet event codes; 5 to 7 are unused and leave the state alone
  typedef enum logic [2:0] {
    MODE_SENT    = 3'd0,
    MODE_ACKED   = 3'd1,
    MODE_LOST    = 3'd2,
    MODE_LOSS    = 3'd3,
    MODE_PERSIST = 3'd4
  } mode_e;

  typedef struct packed {
    logic [31:0] init_window;
    logic [31:0] min_window;
    logic [15:0] max_dgram;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] size;
    logic        counted;
    logic [63:0] sent_time;
    logic [63:0] now_time;
    logic        first_of_ack;
  } item_t;

  typedef struct packed {
    logic [63:0] window;
    logic [63:0] threshold;
    logic [63:0] bytes_outstanding;
    logic        recovering;
    logic [31:0] event_count;
  } result_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? ALL_ONES : s[63:0];
  endfunction

  function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    return (a > b) ? (a - b) : 64'd0;
  endfunction

endpackage

// ===== sv/newreno_congestion_window_top.sv =====
// newreno_congestion_window_top: top level of the NewReno congestion window block.
// Depends on ncw_pkg, ncw_cfg and ncw_core.

// Each transfer on the input channel is one packet event (sent, acked, lost,
// loss round, persistent congestion); each produces exactly one result transfer
// holding the window, threshold, bytes in flight, send permission, recovery flag
// and congestion event count after that event. An event is registered on its
// transfer; once the result slot is free or draining, a single pass of 64-bit add
// and compare logic against the state registers updates the state and loads the
// result register, which drives result valid. One event per cycle is sustained
// as long as results are taken; while a result waits, the input register fills
// and input ready drops, so at most two events sit inside. The state register
// loop (one update per cycle) sets that rate. Configuration writes are registered;
// the window is reset to the package constant, and the configured initial window
// is never loaded into it. Codes 5 to 7 on mode change nothing and just report
// the current state.

module newreno_congestion_window_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [ncw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ncw_pkg::CfgDataW-1:0] cfg_wdata_i,
  // event channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   mode_i,
  input  logic [15:0]                  size_i,
  input  logic                         counted_i,
  input  logic [63:0]                  sent_time_i,
  input  logic [63:0]                  now_time_i,
  input  logic                         first_of_ack_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [63:0]                  window_o,
  output logic [63:0]                  threshold_o,
  output logic [63:0]                  bytes_outstanding_o,
  output logic                         may_send_o,
  output logic                         recovering_o,
  output logic [31:0]                  event_count_o
);

  ncw_pkg::cfg_t    cfg;
  ncw_pkg::item_t   item_q;
  ncw_pkg::result_t nxt;
  ncw_pkg::result_t res_q;
  logic             in_vld_q, out_vld_q;
  logic             advance;

  ncw_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // the held event moves into the update when the result slot is free or draining
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.mode         <= mode_i;
      item_q.size         <= size_i;
      item_q.counted      <= counted_i;
      item_q.sent_time    <= sent_time_i;
      item_q.now_time     <= now_time_i;
      item_q.first_of_ack <= first_of_ack_i;
    end
  end

  ncw_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .item_i (item_q),
    .cfg_i  (cfg),
    .nxt_o  (nxt)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= nxt;
    end
  end

  assign out_valid_o         = out_vld_q;
  assign window_o            = res_q.window;
  assign threshold_o         = res_q.threshold;
  assign bytes_outstanding_o = res_q.bytes_outstanding;
  // send permission follows from the registered window and flight
  assign may_send_o          = res_q.bytes_outstanding < res_q.window;
  assign recovering_o        = res_q.recovering;
  assign event_count_o       = res_q.event_count;

endmodule

// ===== sv/ncw_cfg.sv =====
// ncw_cfg: configuration registers (initial window, minimum window, max datagram).
// Depends on ncw_pkg.

module ncw_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ncw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ncw_pkg::CfgDataW-1:0] cfg_wdata_i,
  output ncw_pkg::cfg_t                cfg_o
);

  ncw_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ncw_pkg::CFG_IDX_INIT_WINDOW: cfg_d.init_window = cfg_wdata_i;
        ncw_pkg::CFG_IDX_MIN_WINDOW:  cfg_d.min_window = cfg_wdata_i;
        ncw_pkg::CFG_IDX_MAX_DGRAM:   cfg_d.max_dgram = cfg_wdata_i[15:0];
        default: ;  // unmapped index
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.init_window <= ncw_pkg::INIT_WINDOW_RST;
      cfg_q.min_window  <= ncw_pkg::MIN_WINDOW_RST;
      cfg_q.max_dgram   <= ncw_pkg::MAX_DGRAM_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/ncw_core.sv =====
// ncw_core: congestion state registers and the per-event update.
// Depends on ncw_pkg.

module ncw_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  ncw_pkg::item_t  item_i,
  input  ncw_pkg::cfg_t   cfg_i,
  output ncw_pkg::result_t nxt_o
);

  logic [63:0] cwnd_q, cwnd_d;
  logic [63:0] ssth_q, ssth_d;
  logic [63:0] credit_q, credit_d;
  logic [63:0] rec_q, rec_d;
  logic [63:0] flight_q, flight_d;
  logic [31:0] events_q, events_d;
  logic        ack_lim_q, ack_lim_d;

  logic [63:0] half_cwnd, max_dgram_w, min_window_w, flight_plus_md, credit_sum, loss_th;
  logic        slow_start, old_pkt, grow_ok;

  assign half_cwnd      = cwnd_q >> 1;
  assign max_dgram_w    = {48'd0, cfg_i.max_dgram};
  assign min_window_w   = {32'd0, cfg_i.min_window};
  assign slow_start     = cwnd_q < ssth_q;
  assign old_pkt        = (rec_q != 64'd0) && (item_i.sent_time <= rec_q);
  assign flight_plus_md = ncw_pkg::sat_add(flight_q, max_dgram_w);
  assign credit_sum     = ncw_pkg::sat_add(credit_q, {48'd0, item_i.size});
  assign loss_th        = (half_cwnd < min_window_w) ? min_window_w : half_cwnd;

  always_comb begin
    cwnd_d    = cwnd_q;
    ssth_d    = ssth_q;
    credit_d  = credit_q;
    rec_d     = rec_q;
    flight_d  = flight_q;
    events_d  = events_q;
    ack_lim_d = ack_lim_q;
    grow_ok   = 1'b0;
    unique case (ncw_pkg::mode_e'(item_i.mode))
      ncw_pkg::MODE_SENT: begin
        if (item_i.counted) flight_d = ncw_pkg::sat_add(flight_q, {48'd0, item_i.size});
      end
      ncw_pkg::MODE_ACKED: begin
        // window-in-use latch is taken before any change
        if (item_i.first_of_ack) begin
          ack_lim_d = slow_start ? (flight_q >= half_cwnd) : (flight_plus_md >= cwnd_q);
        end
        grow_ok = item_i.counted && !old_pkt && ack_lim_d;
        if (grow_ok) begin
          if (slow_start) begin
            cwnd_d = ncw_pkg::sat_add(cwnd_q, {48'd0, item_i.size});
          end else if (credit_sum >= cwnd_q) begin
            credit_d = credit_sum - cwnd_q;
            cwnd_d   = ncw_pkg::sat_add(cwnd_q, max_dgram_w);
          end else begin
            credit_d = credit_sum;
          end
        end
        if (item_i.counted) flight_d = ncw_pkg::sat_sub(flight_q, {48'd0, item_i.size});
      end
      ncw_pkg::MODE_LOST: begin
        if (item_i.counted) flight_d = ncw_pkg::sat_sub(flight_q, {48'd0, item_i.size});
      end
      ncw_pkg::MODE_LOSS: begin
        if (!old_pkt) begin
          rec_d    = item_i.now_time;
          events_d = events_q + 32'd1;
          ssth_d   = loss_th;
          cwnd_d   = loss_th;
          credit_d = 64'd0;
        end
      end
      ncw_pkg::MODE_PERSIST: begin
        cwnd_d   = min_window_w;
        rec_d    = 64'd0;
        credit_d = 64'd0;
      end
      default: ;  // unused codes
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cwnd_q    <= {32'd0, ncw_pkg::INIT_WINDOW_RST};
      ssth_q    <= ncw_pkg::ALL_ONES;
      credit_q  <= 64'd0;
      rec_q     <= 64'd0;
      flight_q  <= 64'd0;
      events_q  <= 32'd0;
      ack_lim_q <= 1'b0;
    end else if (fire_i) begin
      cwnd_q    <= cwnd_d;
      ssth_q    <= ssth_d;
      credit_q  <= credit_d;
      rec_q     <= rec_d;
      flight_q  <= flight_d;
      events_q  <= events_d;
      ack_lim_q <= ack_lim_d;
    end
  end

  assign nxt_o.window            = cwnd_d;
  assign nxt_o.threshold         = ssth_d;
  assign nxt_o.bytes_outstanding = flight_d;
  assign nxt_o.recovering        = rec_d != 64'd0;
  assign nxt_o.event_count       = events_d;

  // event counter moves only on an accepted loss round
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (events_q != $past(events_q)) |->
      ($past(fire_i) && $past(item_i.mode) == ncw_pkg::MODE_LOSS))
    else $error("event counter changed outside a loss round");

  // no accepted event, no state change
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> ($stable(cwnd_q) && $stable(flight_q) && $stable(rec_q) && $stable(ssth_q)))
    else $error("state changed without an event");

  // persistent congestion collapses the window and leaves recovery
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && item_i.mode == ncw_pkg::MODE_PERSIST) |=>
      (cwnd_q == {32'd0, $past(cfg_i.min_window)} && rec_q == 64'd0 && credit_q == 64'd0))
    else $error("persistent congestion did not collapse the window");

  // a sent packet never lowers bytes in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && item_i.mode == ncw_pkg::MODE_SENT) |=> (flight_q >= $past(flight_q)))
    else $error("sent packet reduced bytes in flight");

endmodule
